// ----- hdl/unary_run_header_rank_select_macros.svh -----
// ---------------------------------------------------------------------------
// unary_run_header_rank_select macros
// assertion helpers used by the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef UNARY_RUN_HEADER_RANK_SELECT_MACROS_SVH
`define UNARY_RUN_HEADER_RANK_SELECT_MACROS_SVH

// same-cycle implication, held off during reset
`define URH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urh assertion failed");

// next-cycle implication, held off during reset
`define URH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urh assertion failed");

`endif

// ----- hdl/urh_pkg.sv -----
// ---------------------------------------------------------------------------
// urh_pkg
// types and codes of the unary run header with rank and select
// ---------------------------------------------------------------------------
package urh_pkg;

    // bit positions and counts, wide enough for the largest header
    localparam int POS_W = 11;
    localparam int Q_W   = 5;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // partial search result handed from cell to cell
    typedef struct packed {
        logic             vld;
        logic [Q_W-1:0]   q;
        logic [POS_W-1:0] zeros;
        logic             start_done;
        logic [POS_W-1:0] start;
        logic             end_done;
        logic [POS_W-1:0] stop;
    } t_scan;

    // header rewrite command broadcast to all cells
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_mod;

endpackage

// ----- hdl/urh_cell.sv -----
// ---------------------------------------------------------------------------
// urh_cell
// one header word: rank/select step on the passing search record, and
// in-place insert or remove shift using the neighbor boundary bits
// ---------------------------------------------------------------------------
module urh_cell
    import urh_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_scan                i_scan,
    output t_scan                o_scan,
    input  t_mod                 i_mod,
    input  logic                 i_prev_bit,
    input  logic                 i_next_bit,
    output logic [WORD_BITS-1:0] o_word
);

    localparam logic [POS_W-1:0] BASE = POS_W'(INDEX * WORD_BITS);
    localparam logic [POS_W-1:0] WB   = POS_W'(WORD_BITS);

    logic [WORD_BITS-1:0] r_word, n_word;
    t_scan                r_scan, n_scan;

    logic [WORD_BITS-1:0] zmask;
    logic [POS_W-1:0]     zeros_w;
    logic [POS_W-1:0]     need;
    logic [POS_W-1:0]     sel;
    logic [POS_W-1:0]     first;
    logic [POS_W-1:0]     lb;
    logic [WORD_BITS-1:0] hit;
    logic [WORD_BITS-1:0] endv;
    logic [POS_W-1:0]     gp;

    assign zmask   = ~r_word;
    assign zeros_w = POS_W'($countones(zmask));
    assign need    = POS_W'(i_scan.q) - i_scan.zeros;

    // prefix zero count per bit, bit i is header position BASE + i
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            hit[i] = zmask[i] &&
                (POS_W'($countones(zmask & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - i))))
                 == need);
        end
        sel = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                sel = POS_W'(i);
            end
        end
    end

    always_comb begin
        n_scan = i_scan;
        lb     = '0;
        if (!i_scan.start_done) begin
            if (need <= zeros_w) begin
                n_scan.start_done = 1'b1;
                n_scan.start      = BASE + sel + POS_W'(1);
                lb                = sel + POS_W'(1);
            end else begin
                n_scan.zeros = i_scan.zeros + zeros_w;
                lb           = WB;
            end
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            endv[i] = zmask[i] && (POS_W'(i) >= lb);
        end
        first = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (endv[i]) begin
                first = POS_W'(i);
            end
        end
        if (n_scan.start_done && !i_scan.end_done && (|endv)) begin
            n_scan.end_done = 1'b1;
            n_scan.stop     = BASE + first;
        end
    end

    // insert: one at pos, later bits move toward the end
    // remove: bit at pos dropped, later bits move toward the start
    always_comb begin
        n_word = r_word;
        gp     = BASE;
        for (int i = 0; i < WORD_BITS; i++) begin
            gp = BASE + POS_W'(i);
            if (i_mod.ins && gp == i_mod.pos) begin
                n_word[i] = 1'b1;
            end else if (i_mod.ins && gp > i_mod.pos) begin
                n_word[i] = (i > 0) ? r_word[(i > 0) ? i - 1 : 0] : i_prev_bit;
            end else if (i_mod.rem && gp >= i_mod.pos) begin
                n_word[i] = (i < WORD_BITS - 1) ?
                    r_word[(i < WORD_BITS - 1) ? i + 1 : 0] : i_next_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_scan.vld <= 1'b0;
        end else begin
            r_scan.vld <= n_scan.vld;
            if (i_mod.ins || i_mod.rem) begin
                r_word <= n_word;
            end
        end
        r_scan.q          <= n_scan.q;
        r_scan.zeros      <= n_scan.zeros;
        r_scan.start_done <= n_scan.start_done;
        r_scan.start      <= n_scan.start;
        r_scan.end_done   <= n_scan.end_done;
        r_scan.stop       <= n_scan.stop;
    end

    assign o_scan = r_scan;
    assign o_word = r_word;

endmodule

// ----- hdl/unary_run_header_rank_select.sv -----
// ---------------------------------------------------------------------------
// unary_run_header_rank_select
// unary run header with run lookup, insert and remove
// ---------------------------------------------------------------------------
// usage
//   slave channel: one word per request, tuser carries the operation
//   (lookup, insert, remove), tdata the quotient. master channel: one word
//   per request with the run start, run end, found flag and fill count in
//   tdata and the status code in tuser.
//   the header is a row of word cells. a search record enters the first
//   cell and moves one cell per cycle, each cell doing rank/select on its
//   own word; after the last cell the result is committed and, for insert
//   or remove with ok status, every cell shifts its word together, using the
//   boundary bits of its neighbors.
//   one request is in flight at a time, so a new one is taken only after
//   the walk along the cell row, the capture of the last record and the
//   commit step, once the control is back in the idle state to accept.
//   the result sits in an output register; the next request is accepted
//   while it waits. if the receiver stalls, the following request holds
//   in the commit step until the output register frees.
//   reset: header all zero (every run empty), fill count zero, no result.
// ---------------------------------------------------------------------------
`include "unary_run_header_rank_select_macros.svh"

module unary_run_header_rank_select
    import urh_pkg::*;
#(
    parameter int QUOTIENTS    = 32,
    parameter int CAPACITY     = 32,
    parameter int WORD_BITS    = 32,
    parameter int HEADER_WORDS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [4:0] quotient
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [5:0] run_start, [11:6] run_end, [12] found,
                                     // [18:13] fill_count
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int               HDR     = WORD_BITS * HEADER_WORDS;
    localparam logic [POS_W-1:0] HDR_POS = POS_W'(HDR);
    localparam int               CNT_W   = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    // search chain
    t_scan                w_scan [HEADER_WORDS+1];
    logic [WORD_BITS-1:0] w_word [HEADER_WORDS];
    t_scan                r_seed;
    t_scan                r_res;
    t_mod                 w_mod;
    logic [1:0]           r_op;
    logic [CNT_W-1:0]     r_count;

    // output register
    logic                 r_out_vld;
    logic [23:0]          r_out_tdata;
    logic [1:0]           r_out_tuser;

    logic                 w_accept;
    logic                 w_commit;
    logic                 w_out_free;
    logic [Q_W-1:0]       w_q_eff;
    logic [POS_W-1:0]     w_start;
    logic [POS_W-1:0]     w_stop;
    logic                 w_found;
    logic [1:0]           w_status;
    logic [CNT_W-1:0]     w_count_nxt;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;

    // quotients past the last slot address the last slot
    assign w_q_eff = (int'(i_s_tdata[Q_W-1:0]) >= QUOTIENTS) ?
                     Q_W'(QUOTIENTS - 1) : i_s_tdata[Q_W-1:0];

    // ---------------- cell row ----------------
    assign w_scan[0] = r_seed;

    for (genvar k = 0; k < HEADER_WORDS; k++) begin : g_cell
        logic w_prev_bit;
        logic w_next_bit;
        if (k == 0) begin : g_first
            assign w_prev_bit = 1'b0;
        end else begin : g_mid_prev
            assign w_prev_bit = w_word[k-1][WORD_BITS-1];
        end
        if (k == HEADER_WORDS - 1) begin : g_last
            // fill with zero past the header end
            assign w_next_bit = 1'b0;
        end else begin : g_mid_next
            assign w_next_bit = w_word[k+1][0];
        end
        urh_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_scan     (w_scan[k]),
            .o_scan     (w_scan[k+1]),
            .i_mod      (w_mod),
            .i_prev_bit (w_prev_bit),
            .i_next_bit (w_next_bit),
            .o_word     (w_word[k])
        );
    end

    // ---------------- result of the walk ----------------
    // a missing zero reads as the header length
    assign w_start = r_res.start_done ? r_res.start : HDR_POS;
    assign w_stop  = r_res.end_done   ? r_res.stop  : HDR_POS;
    assign w_found = w_start < w_stop;

    always_comb begin
        w_status    = STS_OK;
        w_count_nxt = r_count;
        case (r_op)
            OP_INSERT: begin
                if (r_count >= CNT_W'(CAPACITY) || w_stop >= HDR_POS) begin
                    w_status = STS_FULL;
                end else begin
                    w_count_nxt = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!w_found) begin
                    w_status = STS_EMPTY;
                end else if (r_count != '0) begin
                    w_count_nxt = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = STS_OK;
            end
        endcase
    end

    // rewrite goes out to every cell in the commit cycle
    always_comb begin
        w_mod.ins = w_commit && (r_op == OP_INSERT) && (w_status == STS_OK);
        w_mod.rem = w_commit && (r_op == OP_REMOVE) && (w_status == STS_OK);
        w_mod.pos = (r_op == OP_REMOVE) ? (w_stop - POS_W'(1)) : w_stop;
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan[HEADER_WORDS].vld) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_SCAN: begin
                o_s_tready = 1'b0;
            end
            S_COMMIT: begin
                w_commit = w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seed.vld <= 1'b0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seed.vld <= w_accept;
            if (w_commit) begin
                r_count   <= w_count_nxt;
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        // payload
        if (w_accept) begin
            r_op              <= i_s_tuser;
            r_seed.q          <= w_q_eff;
            r_seed.zeros      <= '0;
            r_seed.start_done <= (w_q_eff == '0);
            r_seed.start      <= '0;
            r_seed.end_done   <= 1'b0;
            r_seed.stop       <= '0;
        end
        if (w_scan[HEADER_WORDS].vld) begin
            r_res <= w_scan[HEADER_WORDS];
        end
        if (w_commit) begin
            r_out_tdata <= {5'b0, 6'(w_count_nxt), w_found, w_stop[5:0], w_start[5:0]};
            r_out_tuser <= w_status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // ---------------- assertions ----------------
    `URH_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `URH_ASSERT_NXT(a_accept_scan, i_clk, i_rst_n, w_accept, r_state == S_SCAN && r_seed.vld)
    `URH_ASSERT_IMP(a_mod_commit, i_clk, i_rst_n, w_mod.ins || w_mod.rem,
                    w_commit && !(w_mod.ins && w_mod.rem))
    `URH_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, !w_commit, $stable(r_count))
    `URH_ASSERT_NXT(a_commit_out, i_clk, i_rst_n, w_commit, r_out_vld && r_state == S_IDLE)

endmodule
